[rtl/lfs_pkg.sv]
// Shared types, codes and helper functions of the leg force splitter.
`default_nettype none
package lfs_pkg;

    localparam logic [4:0] SLOT_COUNT = 5'd27;
    localparam int         NUM_FORCES = 12;

    localparam logic [4:0] SLOT_BODY  = 5'd0;
    localparam logic [4:0] SLOT_FR    = 5'd3;
    localparam logic [4:0] SLOT_FL    = 5'd6;
    localparam logic [4:0] SLOT_RR    = 5'd9;
    localparam logic [4:0] SLOT_RL    = 5'd12;
    localparam logic [4:0] SLOT_TGT_L = 5'd15;
    localparam logic [4:0] SLOT_TGT_R = 5'd18;
    localparam logic [4:0] SLOT_REF_R = 5'd21;
    localparam logic [4:0] SLOT_REF_L = 5'd24;

    localparam logic [1:0] LEG_FR = 2'd0;
    localparam logic [1:0] LEG_FL = 2'd1;
    localparam logic [1:0] LEG_RR = 2'd2;
    localparam logic [1:0] LEG_RL = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] MODE_PACE = 2'd0;
    localparam logic [1:0] MODE_TROT = 2'd1;

    localparam logic [2:0] MUL_VV = 3'd0;
    localparam logic [2:0] MUL_VW = 3'd1;
    localparam logic [2:0] MUL_TR = 3'd2;
    localparam logic [2:0] MUL_FG = 3'd3;
    localparam logic [2:0] MUL_TG = 3'd4;

    localparam logic [16:0] RATIO_ONE = 17'h10000;

    typedef struct packed {
        logic       st_wr;
        logic       deg_clr;
        logic [4:0] rd_addr;
        logic       opa_ld;
        logic       v_ld;
        logic       w_ld;
        logic       t_ld;
        logic [2:0] mul_sel;
        logic       acc_clr;
        logic       acc_add;
        logic       dot_add;
        logic       sqrt_go;
        logic       dist_ld;
        logic [1:0] dist_idx;
        logic       ratio_go;
        logic       side;
        logic [1:0] first;
        logic [1:0] second;
        logic       f_ld_p;
        logic       tot_ld_t;
        logic       tot_ld_p;
        logic       lf_wr_first;
        logic       lf_wr_second;
        logic [1:0] axis;
        logic       out_ld;
        logic [1:0] out_leg;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
        logic out_free;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [48:0] hi;
        logic signed [48:0] lo;
        hi = 49'sd2147483647;
        lo = -49'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return $signed(v[31:0]);
    endfunction

    // Difference a - b, limited to the symmetric range +-(2^31 - 1).
    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [32:0] hi;
        d  = {a[31], a} - {b[31], b};
        hi = 33'sd2147483647;
        if (d > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (d < -hi) begin
            return 32'sh8000_0001;
        end
        return $signed(d[31:0]);
    endfunction

    function automatic logic [3:0] force_index(input logic [1:0] leg, input logic [1:0] axis);
        return {1'b0, leg, 1'b0} + {2'b0, leg} + {2'b0, axis};
    endfunction

endpackage
`default_nettype wire

[rtl/lfs_sqrt.sv]
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
`default_nettype none
module lfs_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_rad,
    output logic             o_busy,
    output logic [31:0]      o_root
);
    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rad;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[31:0];
endmodule
`default_nettype wire

[rtl/lfs_div.sv]
// Restoring divider for ratios below 2^17: one quotient bit per cycle.
`default_nettype none
module lfs_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_num,
    input  wire logic [32:0] i_den,
    output logic             o_busy,
    output logic [16:0]      o_quo
);
    logic [47:0] r_rem;
    logic [48:0] r_dvs;
    logic [16:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        fits;

    assign fits = {1'b0, r_rem} >= r_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd16) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dvs <= {i_den, 16'b0};
            r_quo <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dvs[47:0];
            end
            r_quo <= {r_quo[15:0], fits};
            r_dvs <= r_dvs >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

[rtl/lfs_dpath.sv]
// Datapath: operand store, shared multiplier, accumulators, ratio logic and force store.
`default_nettype none
module lfs_dpath (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire lfs_pkg::t_cmd i_cmd,
    output lfs_pkg::t_stat    o_stat,
    input  wire logic [1:0]   i_gait_mode,
    input  wire logic [31:0]  i_lateral_gain,
    input  wire logic [4:0]   i_slot,
    input  wire logic [31:0]  i_operand,
    input  wire logic         i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_leg,
    output logic [1:0]        o_axis,
    output logic [31:0]       o_force,
    output logic              o_degen,
    output logic              o_last
);
    import lfs_pkg::*;

    logic [31:0]        r_store [27];
    logic [31:0]        r_rd;
    logic signed [31:0] r_opa;
    logic signed [31:0] r_v;
    logic signed [31:0] r_w;
    logic signed [31:0] r_t;
    logic signed [63:0] r_p;
    logic [63:0]        r_acc;
    logic signed [65:0] r_dot;
    logic [31:0]        r_dist [4];
    logic [16:0]        r_ratio;
    logic               r_use_div;
    logic signed [47:0] r_f;
    logic signed [47:0] r_tot;
    logic signed [31:0] r_lf [NUM_FORCES];
    logic [3:0]         r_deg;
    logic               r_ovalid;
    logic [1:0]         r_oleg;
    logic [1:0]         r_oaxis;
    logic [31:0]        r_oforce;
    logic               r_odegen;
    logic               r_olast;

    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic [16:0]        ratio_q;
    logic [31:0]        sq_root;
    logic               sq_busy;
    logic [16:0]        div_q;
    logic               div_busy;
    logic [31:0]        pace_num;
    logic [31:0]        pace_oth;
    logic [32:0]        pace_den;
    logic               dot_pos;
    logic               dot_full;
    logic               rat_div;
    logic               rat_deg;
    logic [16:0]        rat_fixed;
    logic [47:0]        div_num;
    logic [32:0]        div_den;
    logic [3:0]         idx_first;
    logic [3:0]         idx_second;
    logic [3:0]         idx_out;
    logic signed [48:0] second_val;

    assign ratio_q = r_use_div ? div_q : r_ratio;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_VV: begin
                mx = r_v;
                my = r_v;
            end
            MUL_VW: begin
                mx = r_v;
                my = r_w;
            end
            MUL_TR: begin
                mx = r_t;
                my = $signed({15'b0, ratio_q});
            end
            MUL_FG: begin
                mx = $signed(r_f[31:0]);
                my = $signed(i_lateral_gain);
            end
            MUL_TG: begin
                mx = r_t;
                my = $signed(i_lateral_gain);
            end
            default: begin
                mx = r_v;
                my = r_v;
            end
        endcase
    end

    // Ratio selection: special cases settle it at once, the rest goes to the divider.
    assign pace_num = i_cmd.side ? r_dist[0] : r_dist[1];
    assign pace_oth = i_cmd.side ? r_dist[2] : r_dist[3];
    assign pace_den = {1'b0, pace_num} + {1'b0, pace_oth};
    assign dot_pos  = !r_dot[65] && (r_dot != '0);
    assign dot_full = r_dot >= $signed({18'b0, sq_root, 16'b0});

    always_comb begin
        rat_div   = 1'b0;
        rat_deg   = 1'b0;
        rat_fixed = '0;
        div_num   = {pace_num, 16'b0};
        div_den   = pace_den;
        if (i_gait_mode == MODE_PACE) begin
            if (pace_den == '0) begin
                rat_deg = 1'b1;
            end else begin
                rat_div = 1'b1;
            end
        end else begin
            div_num = r_dot[47:0];
            div_den = {1'b0, sq_root};
            if (sq_root == '0) begin
                rat_deg = 1'b1;
            end else if (!dot_pos) begin
                rat_fixed = '0;
            end else if (dot_full) begin
                rat_fixed = RATIO_ONE;
            end else begin
                rat_div = 1'b1;
            end
        end
    end

    lfs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_go),
        .i_rad   (r_acc),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    lfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.ratio_go && rat_div),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_q)
    );

    assign idx_first  = force_index(i_cmd.first, i_cmd.axis);
    assign idx_second = force_index(i_cmd.second, i_cmd.axis);
    assign idx_out    = force_index(i_cmd.out_leg, i_cmd.axis);
    assign second_val = {r_tot[47], r_tot} - {r_f[47], r_f};

    always_ff @(posedge i_clk) begin
        r_rd <= r_store[i_cmd.rd_addr];
        r_p  <= mx * my;
        if (i_cmd.opa_ld) begin
            r_opa <= $signed(r_rd);
        end
        if (i_cmd.v_ld) begin
            r_v <= sat_diff($signed(r_rd), r_opa);
        end
        if (i_cmd.w_ld) begin
            r_w <= sat_diff($signed(r_rd), r_opa);
        end
        if (i_cmd.t_ld) begin
            r_t <= $signed(r_rd);
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
            r_dot <= '0;
        end else begin
            if (i_cmd.acc_add) begin
                r_acc <= r_acc + $unsigned(r_p);
            end
            if (i_cmd.dot_add) begin
                r_dot <= r_dot + {{2{r_p[63]}}, r_p};
            end
        end
        if (i_cmd.dist_ld) begin
            r_dist[i_cmd.dist_idx] <= sq_root;
        end
        if (i_cmd.ratio_go) begin
            r_use_div <= rat_div;
            r_ratio   <= rat_fixed;
        end
        if (i_cmd.f_ld_p) begin
            r_f <= r_p[63:16];
        end
        if (i_cmd.tot_ld_t) begin
            r_tot <= {{16{r_t[31]}}, r_t};
        end else if (i_cmd.tot_ld_p) begin
            r_tot <= r_p[63:16];
        end
        if (i_cmd.out_ld) begin
            r_oleg   <= i_cmd.out_leg;
            r_oaxis  <= i_cmd.axis;
            r_oforce <= r_lf[idx_out];
            r_odegen <= r_deg[i_cmd.out_leg];
            r_olast  <= i_cmd.out_last;
        end
    end

    // Model state: operand store, held forces and leg degenerate flags, all cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 27; i++) begin
                r_store[i] <= '0;
            end
            for (int i = 0; i < NUM_FORCES; i++) begin
                r_lf[i] <= '0;
            end
            r_deg    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.st_wr && (i_slot < SLOT_COUNT)) begin
                r_store[i_slot] <= i_operand;
            end
            if (i_cmd.deg_clr) begin
                r_deg <= '0;
            end else if (i_cmd.ratio_go && rat_deg) begin
                r_deg[i_cmd.first]  <= 1'b1;
                r_deg[i_cmd.second] <= 1'b1;
            end
            if (i_cmd.lf_wr_first) begin
                r_lf[idx_first] <= sat32({r_f[47], r_f});
            end
            if (i_cmd.lf_wr_second) begin
                r_lf[idx_second] <= sat32(second_val);
            end
            if (i_cmd.out_ld) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.sqrt_busy = sq_busy;
    assign o_stat.div_busy  = div_busy;
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_leg       = r_oleg;
    assign o_axis      = r_oaxis;
    assign o_force     = r_oforce;
    assign o_degen     = r_odegen;
    assign o_last      = r_olast;
endmodule
`default_nettype wire

[rtl/lfs_ctrl.sv]
// Controller: sequences loads, distance and projection sums, ratios, splits and emission.
`default_nettype none
module lfs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_go,
    input  wire logic [1:0]    i_mode,
    input  wire lfs_pkg::t_stat i_stat,
    output logic               o_in_ready,
    output lfs_pkg::t_cmd      o_cmd
);
    import lfs_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_RBASE = 5'd1;
    localparam logic [4:0] ST_RTIP  = 5'd2;
    localparam logic [4:0] ST_RDIF  = 5'd3;
    localparam logic [4:0] ST_WLD   = 5'd4;
    localparam logic [4:0] ST_SQV   = 5'd5;
    localparam logic [4:0] ST_ACCV  = 5'd6;
    localparam logic [4:0] ST_ACCW  = 5'd7;
    localparam logic [4:0] ST_SQS   = 5'd8;
    localparam logic [4:0] ST_SQW   = 5'd9;
    localparam logic [4:0] ST_RAT   = 5'd10;
    localparam logic [4:0] ST_RWT   = 5'd11;
    localparam logic [4:0] ST_SRD   = 5'd12;
    localparam logic [4:0] ST_SLD   = 5'd13;
    localparam logic [4:0] ST_SM1   = 5'd14;
    localparam logic [4:0] ST_SF1   = 5'd15;
    localparam logic [4:0] ST_SM2   = 5'd16;
    localparam logic [4:0] ST_SF2   = 5'd17;
    localparam logic [4:0] ST_SM3   = 5'd18;
    localparam logic [4:0] ST_SF3   = 5'd19;
    localparam logic [4:0] ST_SW1   = 5'd20;
    localparam logic [4:0] ST_SW2   = 5'd21;
    localparam logic [4:0] ST_EMIT  = 5'd22;

    logic [4:0] r_state, n_state;
    logic [1:0] r_k, n_k;
    logic [1:0] r_j, n_j;
    logic       r_side, n_side;
    logic [1:0] r_axis, n_axis;
    logic [1:0] r_oleg, n_oleg;
    logic [1:0] r_oaxis, n_oaxis;

    logic       trot;
    logic [4:0] base_slot;
    logic [4:0] tip_slot;
    logic [4:0] ref_slot;
    logic [4:0] tgt_slot;
    logic       emit_last;

    assign trot      = (i_mode == MODE_TROT);
    assign base_slot = trot ? (r_side ? SLOT_FL : SLOT_FR) : SLOT_BODY;
    assign tip_slot  = trot ? (r_side ? SLOT_RR : SLOT_RL)
                            : SLOT_FR + {2'b0, r_j, 1'b0} + {3'b0, r_j};
    assign ref_slot  = r_side ? SLOT_REF_R : SLOT_REF_L;
    assign tgt_slot  = r_side ? SLOT_TGT_R : SLOT_TGT_L;
    assign emit_last = (r_oleg == LEG_RL) && (r_oaxis == AXIS_Z);

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        n_side  = r_side;
        n_axis  = r_axis;
        n_oleg  = r_oleg;
        n_oaxis = r_oaxis;
        o_cmd        = '0;
        o_cmd.side   = r_side;
        o_cmd.first  = r_side ? LEG_RR : LEG_RL;
        o_cmd.second = trot ? (r_side ? LEG_FL : LEG_FR) : (r_side ? LEG_FR : LEG_FL);
        o_cmd.axis   = r_axis;
        o_cmd.dist_idx = r_j;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.st_wr = 1'b1;
                    if (i_in_go) begin
                        o_cmd.deg_clr = 1'b1;
                        n_k     = '0;
                        n_j     = '0;
                        n_side  = 1'b0;
                        n_oleg  = LEG_FR;
                        n_oaxis = AXIS_X;
                        if (i_mode == MODE_PACE || i_mode == MODE_TROT) begin
                            n_state = ST_RBASE;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_RBASE: begin
                o_cmd.rd_addr = base_slot + {3'b0, r_k};
                o_cmd.acc_clr = (r_k == 2'd0);
                n_state = ST_RTIP;
            end
            ST_RTIP: begin
                o_cmd.opa_ld  = 1'b1;
                o_cmd.rd_addr = tip_slot + {3'b0, r_k};
                n_state = ST_RDIF;
            end
            ST_RDIF: begin
                o_cmd.v_ld    = 1'b1;
                o_cmd.rd_addr = ref_slot + {3'b0, r_k};
                n_state = trot ? ST_WLD : ST_SQV;
            end
            ST_WLD: begin
                o_cmd.w_ld = 1'b1;
                n_state = ST_SQV;
            end
            ST_SQV: begin
                o_cmd.mul_sel = MUL_VV;
                n_state = ST_ACCV;
            end
            ST_ACCV: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.mul_sel = MUL_VW;
                if (trot) begin
                    n_state = ST_ACCW;
                end else if (r_k == 2'd2) begin
                    n_state = ST_SQS;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_RBASE;
                end
            end
            ST_ACCW: begin
                o_cmd.dot_add = 1'b1;
                if (r_k == 2'd2) begin
                    n_state = ST_SQS;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_RBASE;
                end
            end
            ST_SQS: begin
                o_cmd.sqrt_go = 1'b1;
                n_state = ST_SQW;
            end
            ST_SQW: begin
                if (!i_stat.sqrt_busy) begin
                    if (trot) begin
                        n_state = ST_RAT;
                    end else begin
                        o_cmd.dist_ld = 1'b1;
                        n_k = '0;
                        if (r_j == 2'd3) begin
                            n_state = ST_RAT;
                        end else begin
                            n_j     = r_j + 2'd1;
                            n_state = ST_RBASE;
                        end
                    end
                end
            end
            ST_RAT: begin
                o_cmd.ratio_go = 1'b1;
                n_state = ST_RWT;
            end
            ST_RWT: begin
                if (!i_stat.div_busy) begin
                    n_axis  = AXIS_X;
                    n_state = ST_SRD;
                end
            end
            ST_SRD: begin
                o_cmd.rd_addr = tgt_slot + {3'b0, r_axis};
                n_state = ST_SLD;
            end
            ST_SLD: begin
                o_cmd.t_ld = 1'b1;
                n_state = ST_SM1;
            end
            ST_SM1: begin
                o_cmd.mul_sel = MUL_TR;
                n_state = ST_SF1;
            end
            ST_SF1: begin
                o_cmd.f_ld_p   = 1'b1;
                o_cmd.tot_ld_t = 1'b1;
                n_state = (r_axis == AXIS_Y) ? ST_SM2 : ST_SW1;
            end
            ST_SM2: begin
                o_cmd.mul_sel = MUL_FG;
                n_state = ST_SF2;
            end
            ST_SF2: begin
                o_cmd.f_ld_p = 1'b1;
                n_state = ST_SM3;
            end
            ST_SM3: begin
                o_cmd.mul_sel = MUL_TG;
                n_state = ST_SF3;
            end
            ST_SF3: begin
                o_cmd.tot_ld_p = 1'b1;
                n_state = ST_SW1;
            end
            ST_SW1: begin
                o_cmd.lf_wr_first = 1'b1;
                n_state = ST_SW2;
            end
            ST_SW2: begin
                o_cmd.lf_wr_second = 1'b1;
                if (r_axis == AXIS_Z) begin
                    if (!r_side) begin
                        n_side  = 1'b1;
                        n_k     = '0;
                        n_state = trot ? ST_RBASE : ST_RAT;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_SRD;
                end
            end
            ST_EMIT: begin
                o_cmd.out_leg  = r_oleg;
                o_cmd.axis     = r_oaxis;
                o_cmd.out_last = emit_last;
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end else if (r_oaxis == AXIS_Z) begin
                        n_oaxis = AXIS_X;
                        n_oleg  = r_oleg + 2'd1;
                    end else begin
                        n_oaxis = r_oaxis + 2'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_j     <= '0;
            r_side  <= 1'b0;
            r_axis  <= AXIS_X;
            r_oleg  <= LEG_FR;
            r_oaxis <= AXIS_X;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_j     <= n_j;
            r_side  <= n_side;
            r_axis  <= n_axis;
            r_oleg  <= n_oleg;
            r_oaxis <= n_oaxis;
        end
    end
endmodule
`default_nettype wire

[rtl/leg_force_split_by_geometry.sv]
// Top level of the leg force splitter: stream ports, register port, controller and datapath.
//
//  channel   direction  handshake          payload
//  s (in)    slave      tvalid / tready    tdata operand, tuser slot and go
//  m (out)   master     tvalid / tready    tdata force, tuser leg/axis/degenerate, tlast
//  cfg       APB        psel/penable       gait_mode at 0x0, lateral_gain at 0x4
//
// A go request in pace or trot mode runs through the 32-step square root and 17-step
// divider that are shared by all distances and ratios; hold mode only emits. Twelve
// results then leave at up to one per cycle through an output register. Reset is
// synchronous and clears the operand store and the held forces at once. A stalled
// output holds the sequencer.
`default_nettype none
module leg_force_split_by_geometry (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] operand
    input  wire logic [5:0]  i_s_tuser,   // [4:0] slot, [5] go
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] force_res
    output logic [4:0]       o_m_tuser,   // [1:0] leg, [3:2] axis, [4] degenerate
    output logic             o_m_tlast,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);
    import lfs_pkg::*;

    logic [1:0]  r_gait_mode;
    logic [31:0] r_lateral_gain;
    t_cmd        cmd;
    t_stat       stat;
    logic [1:0]  out_leg;
    logic [1:0]  out_axis;
    logic        out_degen;

    // Registers are word aligned, so only address bit 2 selects between them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gait_mode    <= MODE_PACE;
            r_lateral_gain <= 32'h0001_0000;
        end else if (i_psel && i_penable && i_pwrite) begin
            if (i_paddr[2]) begin
                r_lateral_gain <= i_pwdata;
            end else begin
                r_gait_mode <= i_pwdata[1:0];
            end
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = i_paddr[2] ? r_lateral_gain : {30'b0, r_gait_mode};

    lfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_go    (i_s_tuser[5]),
        .i_mode     (r_gait_mode),
        .i_stat     (stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    lfs_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_gait_mode    (r_gait_mode),
        .i_lateral_gain (r_lateral_gain),
        .i_slot         (i_s_tuser[4:0]),
        .i_operand      (i_s_tdata),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_leg          (out_leg),
        .o_axis         (out_axis),
        .o_force        (o_m_tdata),
        .o_degen        (out_degen),
        .o_last         (o_m_tlast)
    );

    assign o_m_tuser = {out_degen, out_axis, out_leg};

    a_go_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser[5]) |=> !o_s_tready)
        else $error("input still ready after a go request");

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (out_leg == LEG_RL && out_axis == AXIS_Z))
        else $error("tlast on a result other than the twelfth");

    a_axis_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (out_axis != 2'd3))
        else $error("invalid axis code on output");
endmodule
`default_nettype wire

[dv/leg_force_split_by_geometry_test.sv]
// Self-checking testbench for the leg force splitter, with its own bit-exact force predictor.
`timescale 1ns / 1ps
module leg_force_split_by_geometry_test;
    import lfs_pkg::*;

    localparam logic [2:0] ADDR_MODE = 3'd0;
    localparam logic [2:0] ADDR_GAIN = 3'd4;
    localparam logic [1:0] MODE_HOLD = 2'd2;
    localparam logic [1:0] MODE_HOLD_ALT = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic [1:0]  leg;
        logic [1:0]  axis;
        logic [31:0] force_val;
        logic        degen;
        logic        last;
    } force_rec_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata = '0;
    logic [5:0]  i_s_tuser = '0;
    logic        i_m_tready = 1'b0;
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [2:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [31:0] o_m_tdata;
    wire  [4:0]  o_m_tuser;
    wire         o_m_tlast;
    wire  [31:0] o_prdata;
    wire         o_pready;

    leg_force_split_by_geometry u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata), .o_prdata(o_prdata), .o_pready(o_pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Predictor state.
    logic [31:0]        opnd_mem [27];
    logic signed [31:0] held_force [12];
    logic               leg_degen [4];
    logic [1:0]         cur_mode = MODE_PACE;
    logic [31:0]        cur_gain = 32'h0001_0000;
    force_rec_t         force_q [$];

    int send_idle = 0;
    int rcv_idle = 0;
    int hold_req = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    function automatic longint opv(int i);
        return longint'($signed(opnd_mem[i]));
    endfunction

    function automatic longint clamp_diff(longint a, longint b);
        longint d;
        d = a - b;
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483647) d = -64'sd2147483647;
        return d;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned foot_span(int a, int b);
        longint unsigned s;
        longint d;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            d = clamp_diff(opv(a + k), opv(b + k));
            s = s + longint'(d * d);
        end
        return int_sqrt(s);
    endfunction

    function automatic longint sum_sat(longint a, longint b);
        if (b > 0 && a > 64'sh7FFF_FFFF_FFFF_FFFF - b) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && a < $signed(64'h8000_0000_0000_0000) - b)
            return $signed(64'h8000_0000_0000_0000);
        return a + b;
    endfunction

    function automatic longint diag_ratio(int base, int tip, int refs, output logic deg);
        longint unsigned len;
        longint dot, v, w;
        len = foot_span(tip, base);
        dot = 0;
        deg = 1'b0;
        if (len == 0) begin
            deg = 1'b1;
            return 0;
        end
        for (int k = 0; k < 3; k++) begin
            v = clamp_diff(opv(tip + k), opv(base + k));
            w = clamp_diff(opv(refs + k), opv(base + k));
            dot = sum_sat(dot, v * w);
        end
        if (dot <= 0) return 0;
        if (longint'(unsigned'(dot)) < 0 || unsigned'(dot) >= len * 65536) return 65536;
        return longint'(unsigned'(dot) / len);
    endfunction

    function automatic longint dist_share(longint unsigned num, longint unsigned other,
                                          output logic deg);
        longint unsigned den;
        den = num + other;
        deg = (den == 0);
        if (deg) return 0;
        return longint'((num << 16) / den);
    endfunction

    function automatic void split_target(int tslot, longint r, int first, int second,
                                         logic deg);
        longint t, f, total, g;
        g = longint'($signed(cur_gain));
        for (int a = 0; a < 3; a++) begin
            t = opv(tslot + a);
            f = qmul(t, r);
            total = t;
            if (a == 1) begin
                f = qmul(f, g);
                total = qmul(t, g);
            end
            held_force[first * 3 + a] = clip32(f);
            held_force[second * 3 + a] = clip32(total - f);
        end
        leg_degen[first] = deg;
        leg_degen[second] = deg;
    endfunction

    function automatic void predict_forces(logic [4:0] slot, logic [31:0] val, logic go);
        longint unsigned dfr, dfl, drr, drl;
        longint rl, rr;
        logic dl, dr;
        force_rec_t rec;
        if (slot < SLOT_COUNT) opnd_mem[slot] = val;
        if (!go) return;
        for (int i = 0; i < 4; i++) leg_degen[i] = 1'b0;
        if (cur_mode == MODE_PACE) begin
            dfr = foot_span(SLOT_FR, SLOT_BODY);
            dfl = foot_span(SLOT_FL, SLOT_BODY);
            drr = foot_span(SLOT_RR, SLOT_BODY);
            drl = foot_span(SLOT_RL, SLOT_BODY);
            rl = dist_share(dfl, drl, dl);
            rr = dist_share(dfr, drr, dr);
            split_target(SLOT_TGT_L, rl, LEG_RL, LEG_FL, dl);
            split_target(SLOT_TGT_R, rr, LEG_RR, LEG_FR, dr);
        end else if (cur_mode == MODE_TROT) begin
            rl = diag_ratio(SLOT_FR, SLOT_RL, SLOT_REF_L, dl);
            rr = diag_ratio(SLOT_FL, SLOT_RR, SLOT_REF_R, dr);
            split_target(SLOT_TGT_L, rl, LEG_RL, LEG_FR, dl);
            split_target(SLOT_TGT_R, rr, LEG_RR, LEG_FL, dr);
        end
        for (int i = 0; i < 12; i++) begin
            rec.leg = 2'(i / 3);
            rec.axis = 2'(i % 3);
            rec.force_val = held_force[i];
            rec.degen = leg_degen[i / 3];
            rec.last = (i == 11);
            force_q.push_back(rec);
        end
    endfunction

    // Output checker.
    always @(posedge i_clk) begin
        force_rec_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (force_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected force result tdata=%h tuser=%h",
                             o_m_tdata, o_m_tuser);
            end else begin
                want = force_q.pop_front();
                if (o_m_tuser[1:0] !== want.leg || o_m_tuser[3:2] !== want.axis ||
                    o_m_tdata !== want.force_val || o_m_tuser[4] !== want.degen ||
                    o_m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: force mismatch exp leg=%0d axis=%0d f=%h deg=%b ",
                                  "last=%b got leg=%0d axis=%0d f=%h deg=%b last=%b"},
                                 want.leg, want.axis, want.force_val, want.degen, want.last,
                                 o_m_tuser[1:0], o_m_tuser[3:2], o_m_tdata, o_m_tuser[4],
                                 o_m_tlast);
                end
            end
        end
    end

    // Receiver readiness, with an occasional long hold-off.
    always @(posedge i_clk) begin
        static int hold_left = 0;
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom % 100) >= rcv_idle;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_req(logic [4:0] slot, logic [31:0] val, logic go);
        while (($urandom % 100) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= val;
        i_s_tuser <= {go, slot};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_forces(slot, val, go);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (force_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] val);
        wait_drained();
        i_psel <= 1'b1;
        i_pwrite <= 1'b1;
        i_paddr <= addr;
        i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        if (addr == ADDR_MODE) cur_mode = val[1:0];
        else if (addr == ADDR_GAIN) cur_gain = val;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom % 10)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3, 4: return $urandom;
            default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    task automatic load_all(logic [31:0] val);
        for (int s = 0; s < 26; s++) send_req(5'(s), val, 1'b0);
        send_req(5'd26, val, 1'b1);
    endtask

    task automatic test_extremes();
        // All-zero store: both pace sides have a zero denominator.
        send_req(SLOT_BODY, 32'd0, 1'b1);
        load_all(32'h7FFF_FFFF);
        for (int s = 0; s < 27; s += 2) send_req(5'(s), 32'h8000_0000, 1'b0);
        send_req(SLOT_TGT_L + 5'd1, 32'h0003_0000, 1'b1);
        send_req(5'd31, 32'h1234_5678, 1'b1);
    endtask

    task automatic test_trot();
        write_reg(ADDR_MODE, 32'(MODE_TROT));
        send_req(SLOT_REF_L, 32'h8000_0000, 1'b1);
        send_req(SLOT_RL, 32'h0002_0000, 1'b0);
        send_req(SLOT_REF_L, 32'h0001_0000, 1'b0);
        send_req(SLOT_RR + 5'd1, 32'hFFFE_0000, 1'b0);
        send_req(SLOT_REF_R + 5'd2, 32'h7FFF_FFFF, 1'b1);
        load_all(32'h0001_0000);
    endtask

    task automatic test_hold_and_gain();
        write_reg(ADDR_MODE, 32'(MODE_PACE));
        write_reg(ADDR_GAIN, 32'h8000_0000);
        send_req(SLOT_TGT_R + 5'd1, 32'h7FFF_FFFF, 1'b1);
        write_reg(ADDR_GAIN, 32'h7FFF_FFFF);
        send_req(SLOT_TGT_L + 5'd1, 32'h8000_0000, 1'b1);
        write_reg(ADDR_MODE, 32'(MODE_HOLD));
        send_req(SLOT_TGT_L, 32'h0000_1000, 1'b1);
        write_reg(ADDR_MODE, 32'(MODE_HOLD_ALT));
        send_req(5'd27, 32'hFFFF_FFFF, 1'b1);
        write_reg(ADDR_GAIN, 32'd0);
    endtask

    // Mostly well-formed loads of random operands followed by go, with some noise.
    task automatic random_traffic(int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count) begin
            if (($urandom % 5) != 0) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_req(5'($urandom_range(0, 26)), pick_value(), 1'b0);
                send_req(5'($urandom_range(0, 26)), pick_value(), 1'b1);
                sent += n + 1;
            end else begin
                send_req(5'($urandom_range(0, 31)), $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    task automatic test_random_phases();
        write_reg(ADDR_GAIN, 32'h0001_0000);
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle = 0;  rcv_idle = 0;  end
                1: begin send_idle = 81; rcv_idle = 0;  end
                2: begin send_idle = 0;  rcv_idle = 81; end
                default: begin send_idle = 10; rcv_idle = 10; end
            endcase
            write_reg(ADDR_MODE, p % 3);
            if (p == 3) write_reg(ADDR_GAIN, $urandom);
            random_traffic(85);
        end
        send_idle = 0;
        rcv_idle = 0;
    endtask

    task automatic test_backpressure();
        write_reg(ADDR_MODE, 32'(MODE_TROT));
        hold_req = 3000;
        for (int i = 0; i < 30; i++)
            send_req(5'($urandom_range(0, 26)), pick_value(), 1'b1);
        // Sender pauses here until every expected force has come back.
        wait_drained();
        write_reg(ADDR_MODE, 32'(MODE_PACE));
        for (int i = 0; i < 10; i++)
            send_req(5'($urandom_range(0, 26)), pick_value(), i[0]);
    endtask

    initial begin
        for (int i = 0; i < 27; i++) opnd_mem[i] = '0;
        for (int i = 0; i < 12; i++) held_force[i] = '0;
        for (int i = 0; i < 4; i++) leg_degen[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_trot();
        test_hold_and_gain();
        test_random_phases();
        test_backpressure();
        wait_drained();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
